@@ design/ptrs_pkg.sv @@
// ----------------------------------------------------------------------------
// ptrs_pkg: pan/tilt rate servo controller package
// Command codes, register indexes, reset values, fixed-point constants and the
// control and status bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package ptrs_pkg;

  typedef enum logic [2:0] {
    CMD_RAW_SET  = 3'd0,
    CMD_LIM_SET  = 3'd1,
    CMD_STEP     = 3'd2,
    CMD_SET_RATE = 3'd3,
    CMD_TICK     = 3'd4,
    CMD_HOME     = 3'd5
  } cmd_e;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_PAN_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX = 3'd7;

  localparam logic [7:0]  RST_LIM_MIN   = 8'd0;
  localparam logic [7:0]  RST_LIM_MAX   = 8'd180;
  localparam logic [9:0]  RST_MAX_RATE  = 10'd90;
  localparam logic [9:0]  RST_MAX_STEP  = 10'd100;
  localparam logic [11:0] RST_PULSE_MIN = 12'd544;
  localparam logic [11:0] RST_PULSE_MAX = 12'd2400;

  localparam int PAN_HOME_DEG_DEF  = 90;
  localparam int TILT_HOME_DEG_DEF = 90;

  localparam logic [7:0]  FULL_DEG     = 8'd180;
  localparam logic [17:0] MDEG_PER_DEG = 18'd1000;
  localparam logic [17:0] FULL_MDEG    = 18'd180000;

  // floor(x / 1000) = (x * DEG_RECIP) >> 28, exact for x up to 255000.
  localparam logic [18:0] DEG_RECIP = 19'd268436;
  // floor(y / 5625) = (y * PULSE_RECIP) >> 37, exact for y below 2^25.
  // 180000 = 32 * 5625, so the pulse quotient drops five bits first.
  localparam logic [24:0] PULSE_RECIP = 25'd24433592;

  typedef struct packed {
    logic latch;
    logic exec;
    logic mul;
    logic intg;
    logic cv1;
    logic cv2;
    logic load;
  } ctrl_t;

  typedef struct packed {
    logic is_tick;
  } status_t;

endpackage

@@ design/ptrs_if.sv @@
// ----------------------------------------------------------------------------
// ptrs_if: command and result channels
// Valid/ready channels for command words in and result words out.
// ----------------------------------------------------------------------------
interface ptrs_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic               axis;
  logic signed [15:0] value;
  logic [31:0]        now_ms;

  modport source (output valid, command, axis, value, now_ms, input ready);
  modport sink   (input valid, command, axis, value, now_ms, output ready);
endinterface

interface ptrs_out_if;
  logic               valid;
  logic               ready;
  logic [11:0]        pan_pulse_us;
  logic [11:0]        tilt_pulse_us;
  logic               pan_written;
  logic               tilt_written;
  logic [7:0]         pan_deg;
  logic [7:0]         tilt_deg;
  logic signed [10:0] pan_rate_dps;
  logic signed [10:0] tilt_rate_dps;

  modport source (output valid, pan_pulse_us, tilt_pulse_us, pan_written, tilt_written,
                  pan_deg, tilt_deg, pan_rate_dps, tilt_rate_dps, input ready);
  modport sink   (input valid, pan_pulse_us, tilt_pulse_us, pan_written, tilt_written,
                  pan_deg, tilt_deg, pan_rate_dps, tilt_rate_dps, output ready);
endinterface

@@ design/ptrs_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptrs_ctrl: sequencing state machine
// Walks one command word through execute, tick integration, pulse conversion
// and the result register, and runs both channel handshakes.
// ----------------------------------------------------------------------------
module ptrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ptrs_pkg::status_t status_i,
  output ptrs_pkg::ctrl_t   ctrl_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_INTG,
    ST_CV1,
    ST_CV2,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   load;

  assign load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    ctrl_o       = '0;
    ctrl_o.latch = (state_q == ST_IDLE) && in_valid_i;
    ctrl_o.exec  = (state_q == ST_EXEC);
    ctrl_o.mul   = (state_q == ST_MUL);
    ctrl_o.intg  = (state_q == ST_INTG);
    ctrl_o.cv1   = (state_q == ST_CV1);
    ctrl_o.cv2   = (state_q == ST_CV2);
    ctrl_o.load  = load;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          state_q <= status_i.is_tick ? ST_MUL : ST_CV1;
        end
        ST_MUL:  state_q <= ST_INTG;
        ST_INTG: state_q <= ST_CV1;
        ST_CV1:  state_q <= ST_CV2;
        ST_CV2:  state_q <= ST_FIN;
        ST_FIN: begin
          // The result waits here only while the previous word is still unread.
          if (load) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ design/ptrs_datapath.sv @@
// ----------------------------------------------------------------------------
// ptrs_datapath: axis state, configuration and arithmetic
// Holds the registers, applies commands, integrates rates on ticks and maps
// positions to whole degrees and pulse widths with reciprocal multiplies.
// ----------------------------------------------------------------------------
module ptrs_datapath #(
  parameter int PAN_HOME_DEG  = ptrs_pkg::PAN_HOME_DEG_DEF,
  parameter int TILT_HOME_DEG = ptrs_pkg::TILT_HOME_DEG_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ptrs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ptrs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  ptrs_pkg::ctrl_t                 ctrl_i,
  output ptrs_pkg::status_t               status_o,
  input  logic [2:0]                      command_i,
  input  logic                            axis_i,
  input  logic signed [15:0]              value_i,
  input  logic [31:0]                     now_ms_i,
  output logic [1:0][11:0]                pulse_us_o,
  output logic [1:0]                      written_o,
  output logic [1:0][7:0]                 deg_o,
  output logic [1:0][10:0]                rate_dps_o
);

  function automatic logic [7:0] clamp_deg(logic signed [16:0] v, logic [7:0] lo,
                                           logic [7:0] hi);
    logic signed [16:0] lo_s;
    logic signed [16:0] hi_s;
    logic [7:0]         r;
    lo_s = {9'b0, lo};
    hi_s = {9'b0, hi};
    if (v < lo_s) begin
      r = lo;
    end else if (v > hi_s) begin
      r = hi;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  function automatic logic [17:0] to_mdeg(logic [7:0] d);
    return {10'b0, d} * ptrs_pkg::MDEG_PER_DEG;
  endfunction

  localparam logic [17:0] PAN_HOME_MDEG  = 18'(PAN_HOME_DEG * 1000);
  localparam logic [17:0] TILT_HOME_MDEG = 18'(TILT_HOME_DEG * 1000);

  // Configuration.
  logic [7:0]  lim_lo_q [2];
  logic [7:0]  lim_hi_q [2];
  logic [9:0]  max_rate_q;
  logic [9:0]  max_step_q;
  logic [11:0] pmin_q;
  logic [11:0] pmax_q;

  // Latched command word.
  logic [2:0]         cmd_q;
  logic               axis_q;
  logic signed [15:0] value_q;
  logic [31:0]        now_q;

  // Axis state.
  logic [17:0]        pos_q  [2];
  logic signed [10:0] rate_q [2];
  logic [7:0]         deg_q  [2];
  logic [31:0]        last_q;

  // Work registers.
  logic [9:0]         dt_q;
  logic [1:0]         move_q;
  logic [1:0]         wr_q;
  logic signed [21:0] prod_q [2];
  logic [29:0]        p1_q   [2];
  logic [11:0]        quo_q  [2];

  // Result registers.
  logic [11:0] o_pulse_q [2];
  logic [1:0]  o_wr_q;
  logic [7:0]  o_deg_q   [2];
  logic [10:0] o_rate_q  [2];

  // Execute-stage next values.
  logic [17:0]        pos_x  [2];
  logic signed [10:0] rate_x [2];
  logic [31:0]        last_x;
  logic [9:0]         dt_x;
  logic [1:0]         move_x;
  logic [1:0]         wr_x;
  logic signed [16:0] val_ext;
  logic signed [16:0] step_sum;
  logic signed [16:0] rmax_s;
  logic [31:0]        dt_full;
  logic [7:0]         lo_a;
  logic [7:0]         hi_a;

  // Integration and conversion terms.
  logic [17:0]        intg_pos  [2];
  logic signed [10:0] intg_rate [2];
  logic [29:0]        p1_x      [2];
  logic [36:0]        degp_x    [2];
  logic [49:0]        qp_x      [2];
  logic [11:0]        span;

  assign status_o.is_tick = (cmd_q == ptrs_pkg::CMD_TICK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_lo_q[0] <= ptrs_pkg::RST_LIM_MIN;
      lim_hi_q[0] <= ptrs_pkg::RST_LIM_MAX;
      lim_lo_q[1] <= ptrs_pkg::RST_LIM_MIN;
      lim_hi_q[1] <= ptrs_pkg::RST_LIM_MAX;
      max_rate_q  <= ptrs_pkg::RST_MAX_RATE;
      max_step_q  <= ptrs_pkg::RST_MAX_STEP;
      pmin_q      <= ptrs_pkg::RST_PULSE_MIN;
      pmax_q      <= ptrs_pkg::RST_PULSE_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ptrs_pkg::REG_PAN_MIN:   lim_lo_q[0] <= cfg_data_i[7:0];
        ptrs_pkg::REG_PAN_MAX:   lim_hi_q[0] <= cfg_data_i[7:0];
        ptrs_pkg::REG_TILT_MIN:  lim_lo_q[1] <= cfg_data_i[7:0];
        ptrs_pkg::REG_TILT_MAX:  lim_hi_q[1] <= cfg_data_i[7:0];
        ptrs_pkg::REG_MAX_RATE:  max_rate_q  <= cfg_data_i[9:0];
        ptrs_pkg::REG_MAX_STEP:  max_step_q  <= cfg_data_i[9:0];
        ptrs_pkg::REG_PULSE_MIN: pmin_q      <= cfg_data_i;
        ptrs_pkg::REG_PULSE_MAX: pmax_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q   <= command_i;
      axis_q  <= axis_i;
      value_q <= value_i;
      now_q   <= now_ms_i;
    end
  end

  always_comb begin
    pos_x    = pos_q;
    rate_x   = rate_q;
    last_x   = last_q;
    dt_x     = dt_q;
    move_x   = '0;
    wr_x     = '0;
    lo_a     = lim_lo_q[axis_q];
    hi_a     = lim_hi_q[axis_q];
    val_ext  = {value_q[15], value_q};
    step_sum = $signed({9'b0, deg_q[axis_q]}) + val_ext;
    rmax_s   = {7'b0, max_rate_q};
    dt_full  = now_q - last_q;
    unique case (cmd_q)
      ptrs_pkg::CMD_RAW_SET: begin
        pos_x[axis_q]  = to_mdeg(clamp_deg(val_ext, 8'd0, ptrs_pkg::FULL_DEG));
        rate_x[axis_q] = '0;
        wr_x[axis_q]   = 1'b1;
      end
      ptrs_pkg::CMD_LIM_SET: begin
        pos_x[axis_q]  = to_mdeg(clamp_deg(val_ext, lo_a, hi_a));
        rate_x[axis_q] = '0;
        wr_x[axis_q]   = 1'b1;
      end
      ptrs_pkg::CMD_STEP: begin
        pos_x[axis_q]  = to_mdeg(clamp_deg(step_sum, lo_a, hi_a));
        rate_x[axis_q] = '0;
        wr_x[axis_q]   = 1'b1;
      end
      ptrs_pkg::CMD_SET_RATE: begin
        if (val_ext < -rmax_s) begin
          rate_x[axis_q] = 11'(-rmax_s);
        end else if (val_ext > rmax_s) begin
          rate_x[axis_q] = 11'(rmax_s);
        end else begin
          rate_x[axis_q] = val_ext[10:0];
        end
      end
      ptrs_pkg::CMD_TICK: begin
        last_x = now_q;
        if ((rate_q[0] != '0 || rate_q[1] != '0) && dt_full != '0) begin
          dt_x      = (dt_full > {22'b0, max_step_q}) ? max_step_q : dt_full[9:0];
          move_x[0] = (rate_q[0] != '0);
          move_x[1] = (rate_q[1] != '0);
          wr_x      = move_x;
        end
      end
      ptrs_pkg::CMD_HOME: begin
        pos_x[0]  = to_mdeg(clamp_deg(17'(PAN_HOME_DEG), lim_lo_q[0], lim_hi_q[0]));
        pos_x[1]  = to_mdeg(clamp_deg(17'(TILT_HOME_DEG), lim_lo_q[1], lim_hi_q[1]));
        rate_x[0] = '0;
        rate_x[1] = '0;
        wr_x      = 2'b11;
      end
      default: ;
    endcase
  end

  always_comb begin
    span = (pmax_q > pmin_q) ? (pmax_q - pmin_q) : 12'd0;
    for (int k = 0; k < 2; k++) begin
      logic signed [22:0] sum;
      logic [17:0]        lo_m;
      logic [17:0]        hi_m;
      logic [17:0]        mcl;
      sum  = $signed({5'b0, pos_q[k]}) + $signed({prod_q[k][21], prod_q[k]});
      lo_m = to_mdeg(lim_lo_q[k]);
      hi_m = to_mdeg(lim_hi_q[k]);
      intg_pos[k]  = pos_q[k];
      intg_rate[k] = rate_q[k];
      // The low limit is tested first; with inverted limits a sum below it settles on it, else on the high one.
      if (move_q[k]) begin
        if (sum < $signed({5'b0, lo_m})) begin
          intg_pos[k]  = lo_m;
          intg_rate[k] = '0;
        end else if (sum > $signed({5'b0, hi_m})) begin
          intg_pos[k]  = hi_m;
          intg_rate[k] = '0;
        end else begin
          intg_pos[k] = sum[17:0];
        end
      end
      mcl       = (pos_q[k] > ptrs_pkg::FULL_MDEG) ? ptrs_pkg::FULL_MDEG : pos_q[k];
      p1_x[k]   = 30'(mcl) * 30'(span);
      degp_x[k] = 37'(pos_q[k]) * 37'(ptrs_pkg::DEG_RECIP);
      qp_x[k]   = 50'(p1_q[k][29:5]) * 50'(ptrs_pkg::PULSE_RECIP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q[0]  <= PAN_HOME_MDEG;
      pos_q[1]  <= TILT_HOME_MDEG;
      rate_q[0] <= '0;
      rate_q[1] <= '0;
      deg_q[0]  <= 8'(PAN_HOME_DEG);
      deg_q[1]  <= 8'(TILT_HOME_DEG);
      last_q    <= '0;
      move_q    <= '0;
      wr_q      <= '0;
    end else begin
      if (ctrl_i.exec) begin
        pos_q  <= pos_x;
        rate_q <= rate_x;
        last_q <= last_x;
        move_q <= move_x;
        wr_q   <= wr_x;
      end else if (ctrl_i.intg) begin
        pos_q  <= intg_pos;
        rate_q <= intg_rate;
      end
      if (ctrl_i.cv1) begin
        deg_q[0] <= degp_x[0][35:28];
        deg_q[1] <= degp_x[1][35:28];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) dt_q <= dt_x;
    for (int k = 0; k < 2; k++) begin
      if (ctrl_i.mul) prod_q[k] <= 22'(rate_q[k]) * 22'($signed({1'b0, dt_q}));
      if (ctrl_i.cv1) p1_q[k] <= p1_x[k];
      if (ctrl_i.cv2) quo_q[k] <= qp_x[k][48:37];
      if (ctrl_i.load) begin
        o_pulse_q[k] <= pmin_q + quo_q[k];
        o_deg_q[k]   <= deg_q[k];
        o_rate_q[k]  <= rate_q[k];
      end
    end
    if (ctrl_i.load) o_wr_q <= wr_q;
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      pulse_us_o[k] = o_pulse_q[k];
      deg_o[k]      = o_deg_q[k];
      rate_dps_o[k] = o_rate_q[k];
    end
    written_o = o_wr_q;
  end

endmodule

@@ design/pan_tilt_rate_servo_controller_top.sv @@
// An accepted word passes execute, the rate multiply and integration (ticks only), the
// conversion states and the finish state; one word is in flight at a time,
// paced by the sequencer through execute, the rate multiply and the pulse reciprocals.
// A finished result waits in the output register while the next word is accepted.
// Reset (rst_ni low, asynchronous) loads the register defaults, puts both axes at
// home with zero rate, clears the tick time and drops any pending result.
// ----------------------------------------------------------------------------
// pan_tilt_rate_servo_controller_top: two-axis pan/tilt servo positioner
// Joins the sequencing state machine and the datapath to the channels.
// ----------------------------------------------------------------------------
module pan_tilt_rate_servo_controller_top #(
  parameter int PAN_HOME_DEG  = ptrs_pkg::PAN_HOME_DEG_DEF,
  parameter int TILT_HOME_DEG = ptrs_pkg::TILT_HOME_DEG_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ptrs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ptrs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ptrs_in_if.sink                         in_i,
  ptrs_out_if.source                      out_o
);

  ptrs_pkg::ctrl_t   ctrl;
  ptrs_pkg::status_t status;
  logic [1:0][11:0]  pulse_us;
  logic [1:0]        written;
  logic [1:0][7:0]   deg;
  logic [1:0][10:0]  rate_dps;

  ptrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  ptrs_datapath #(
    .PAN_HOME_DEG  (PAN_HOME_DEG),
    .TILT_HOME_DEG (TILT_HOME_DEG)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ctrl_i     (ctrl),
    .status_o   (status),
    .command_i  (in_i.command),
    .axis_i     (in_i.axis),
    .value_i    (in_i.value),
    .now_ms_i   (in_i.now_ms),
    .pulse_us_o (pulse_us),
    .written_o  (written),
    .deg_o      (deg),
    .rate_dps_o (rate_dps)
  );

  assign out_o.pan_pulse_us  = pulse_us[0];
  assign out_o.tilt_pulse_us = pulse_us[1];
  assign out_o.pan_written   = written[0];
  assign out_o.tilt_written  = written[1];
  assign out_o.pan_deg       = deg[0];
  assign out_o.tilt_deg      = deg[1];
  assign out_o.pan_rate_dps  = $signed(rate_dps[0]);
  assign out_o.tilt_rate_dps = $signed(rate_dps[1]);

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: pan/tilt rate servo controller
// Feeds command words through the input channel with random gaps, predicts
// each readout word from an independent model of both axes, and checks the
// readouts in order while the output side stalls at random. The run covers
// several register settings, among them inverted limits and pulse ranges.
// ----------------------------------------------------------------------------
module testbench;
  import ptrs_pkg::*;

  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam longint MILLI     = 1000;
  localparam longint TOP_DEG   = 180;
  localparam longint SPAN_MDEG = 180000;

  typedef struct packed {
    logic [2:0]         command;
    logic               axis;
    logic signed [15:0] value;
    logic [31:0]        now_ms;
  } cmd_word_t;

  typedef struct packed {
    logic [11:0]        pan_pulse;
    logic [11:0]        tilt_pulse;
    logic               pan_wr;
    logic               tilt_wr;
    logic [7:0]         pan_deg;
    logic [7:0]         tilt_deg;
    logic signed [10:0] pan_rate;
    logic signed [10:0] tilt_rate;
  } readout_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ptrs_in_if  cmd_if ();
  ptrs_out_if rd_if ();

  pan_tilt_rate_servo_controller_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (cmd_if),
    .out_o      (rd_if)
  );

  // Servo state as the testbench sees it.
  longint       axis_mdeg [2];
  int           axis_rate [2];
  logic [31:0]  last_tick;
  logic [11:0]  cfg_reg [8];
  logic [11:0]  next_regs [8];

  cmd_word_t    cmd_q [$];
  readout_t     readout_q [$];
  readout_t     exp_rd;
  readout_t     got_rd;
  cmd_word_t    drv_word;
  int           errors;
  int           taken_cnt;
  int           sent_cnt;
  int           rd_cnt;
  int           seen_cnt;
  int           send_gap;
  int           recv_stall;
  bit           send_burst;
  bit           recv_burst;
  logic [31:0]  stim_ms;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint clampl(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint lim_lo(input int a);
    return longint'(a ? cfg_reg[REG_TILT_MIN] : cfg_reg[REG_PAN_MIN]);
  endfunction

  function automatic longint lim_hi(input int a);
    return longint'(a ? cfg_reg[REG_TILT_MAX] : cfg_reg[REG_PAN_MAX]);
  endfunction

  function automatic logic [11:0] pulse_of(input longint m);
    longint lo;
    longint hi;
    longint span;
    lo   = longint'(cfg_reg[REG_PULSE_MIN]);
    hi   = longint'(cfg_reg[REG_PULSE_MAX]);
    span = (hi > lo) ? hi - lo : 0;
    m    = clampl(m, 0, SPAN_MDEG);
    return 12'(lo + m * span / SPAN_MDEG);
  endfunction

  // The low limit is tested first; with inverted limits a value below it resolves to it, else to the high one.
  task automatic settle_axis(input int a, input longint deg);
    axis_mdeg[a] = clampl(deg, lim_lo(a), lim_hi(a)) * MILLI;
    axis_rate[a] = 0;
  endtask

  task automatic predict_readout(input logic [2:0] cmd, input logic ax,
                                 input logic signed [15:0] val, input logic [31:0] now,
                                 output readout_t r);
    longint      v;
    longint      lo;
    longint      hi;
    logic [31:0] dt;
    logic [1:0]  wr;
    int          k;
    v  = val;
    wr = 2'b00;
    case (cmd)
      CMD_RAW_SET: begin
        axis_mdeg[ax] = clampl(v, 0, TOP_DEG) * MILLI;
        axis_rate[ax] = 0;
        wr[ax] = 1'b1;
      end
      CMD_LIM_SET: begin
        settle_axis(ax, v);
        wr[ax] = 1'b1;
      end
      CMD_STEP: begin
        settle_axis(ax, axis_mdeg[ax] / MILLI + v);
        wr[ax] = 1'b1;
      end
      CMD_SET_RATE: begin
        hi = longint'(cfg_reg[REG_MAX_RATE]);
        axis_rate[ax] = int'(clampl(v, -hi, hi));
      end
      CMD_TICK: begin
        dt = now - last_tick;
        last_tick = now;
        if ((axis_rate[0] != 0 || axis_rate[1] != 0) && dt != 0) begin
          if (dt > cfg_reg[REG_MAX_STEP]) dt = cfg_reg[REG_MAX_STEP];
          for (k = 0; k < 2; k++) begin
            if (axis_rate[k] != 0) begin
              lo = lim_lo(k) * MILLI;
              hi = lim_hi(k) * MILLI;
              axis_mdeg[k] = axis_mdeg[k] + longint'(axis_rate[k]) * longint'(dt);
              if (axis_mdeg[k] < lo) begin
                axis_mdeg[k] = lo;
                axis_rate[k] = 0;
              end else if (axis_mdeg[k] > hi) begin
                axis_mdeg[k] = hi;
                axis_rate[k] = 0;
              end
              wr[k] = 1'b1;
            end
          end
        end
      end
      CMD_HOME: begin
        settle_axis(0, PAN_HOME_DEG_DEF);
        settle_axis(1, TILT_HOME_DEG_DEF);
        wr = 2'b11;
      end
      default: ;
    endcase
    r.pan_pulse  = pulse_of(axis_mdeg[0]);
    r.tilt_pulse = pulse_of(axis_mdeg[1]);
    r.pan_wr     = wr[0];
    r.tilt_wr    = wr[1];
    r.pan_deg    = 8'(axis_mdeg[0] / MILLI);
    r.tilt_deg   = 8'(axis_mdeg[1] / MILLI);
    r.pan_rate   = 11'(axis_rate[0]);
    r.tilt_rate  = 11'(axis_rate[1]);
  endtask

  function automatic int draw_idle(input bit burst);
    return burst ? 0 : $urandom_range(0, 17);
  endfunction

  // Mostly values in [lo, hi], now and then any 16-bit value.
  function automatic logic signed [15:0] pick_value(input int lo, input int hi);
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, hi - lo) + lo);
  endfunction

  task automatic push_cmd(input logic [2:0] cmd, input logic ax,
                          input logic signed [15:0] val, input logic [31:0] now);
    cmd_word_t w;
    w.command = cmd;
    w.axis    = ax;
    w.value   = val;
    w.now_ms  = now;
    cmd_q.push_back(w);
  endtask

  task automatic wait_idle();
    while (cmd_q.size() != 0 || readout_q.size() != 0 || cmd_if.valid) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic program_regs();
    int i;
    for (i = 0; i < 8; i++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'(i);
      cfg_data_i <= next_regs[i];
      cfg_reg[i] = next_regs[i];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic pick_config(input int ph);
    int a;
    int lo;
    case (ph)
      0: begin
        next_regs[REG_PAN_MIN]  = 0;    next_regs[REG_PAN_MAX]  = 180;
        next_regs[REG_TILT_MIN] = 0;    next_regs[REG_TILT_MAX] = 180;
        next_regs[REG_MAX_RATE] = 1000; next_regs[REG_MAX_STEP] = 1000;
        next_regs[REG_PULSE_MIN] = 0;   next_regs[REG_PULSE_MAX] = 4095;
      end
      1: begin
        next_regs[REG_PAN_MIN]  = 60;   next_regs[REG_PAN_MAX]  = 120;
        next_regs[REG_TILT_MIN] = 45;   next_regs[REG_TILT_MAX] = 135;
        next_regs[REG_MAX_RATE] = 0;    next_regs[REG_MAX_STEP] = 1;
        next_regs[REG_PULSE_MIN] = 544; next_regs[REG_PULSE_MAX] = 2400;
      end
      2: begin
        next_regs[REG_PAN_MIN]  = 0;    next_regs[REG_PAN_MAX]  = 255;
        next_regs[REG_TILT_MIN] = 100;  next_regs[REG_TILT_MAX] = 255;
        next_regs[REG_MAX_RATE] = 500;  next_regs[REG_MAX_STEP] = 1000;
        next_regs[REG_PULSE_MIN] = 1000; next_regs[REG_PULSE_MAX] = 2000;
      end
      default: begin
        for (a = 0; a < 2; a++) begin
          lo = $urandom_range(0, 180);
          next_regs[REG_PAN_MIN + 2 * a] = lo;
          next_regs[REG_PAN_MAX + 2 * a] = ($urandom_range(0, 4) == 0) ?
                                           $urandom_range(0, 255) : $urandom_range(lo, 180);
        end
        next_regs[REG_MAX_RATE]  = $urandom_range(0, 1000);
        next_regs[REG_MAX_STEP]  = $urandom_range(1, 1000);
        lo = $urandom_range(0, 2500);
        next_regs[REG_PULSE_MIN] = lo;
        next_regs[REG_PULSE_MAX] = ($urandom_range(0, 4) == 0) ?
                                   $urandom_range(0, 4095) : $urandom_range(lo, 4095);
      end
    endcase
  endtask

  // Most words form motion runs: rates followed by a train of ticks, so that
  // axes travel into their limits. The rest are sets, steps, homes and noise.
  task automatic queue_random(input int n);
    int   goal;
    int   kind;
    int   reps;
    int   j;
    int   m;
    logic ax;
    goal = cmd_q.size() + n;
    while (cmd_q.size() < goal) begin
      kind = $urandom_range(0, 9);
      ax   = 1'($urandom_range(0, 1));
      m    = cfg_reg[REG_MAX_RATE];
      case (kind)
        0, 1, 2, 3: begin
          push_cmd(CMD_SET_RATE, ax, pick_value(-m - 50, m + 50), $urandom);
          if ($urandom_range(0, 1) == 1)
            push_cmd(CMD_SET_RATE, !ax, pick_value(-m - 50, m + 50), $urandom);
          reps = $urandom_range(2, 10);
          for (j = 0; j < reps; j++) begin
            case ($urandom_range(0, 9))
              0:       ;
              1:       stim_ms = stim_ms + $urandom_range(120, 1500);
              2:       stim_ms = $urandom;
              default: stim_ms = stim_ms + $urandom_range(1, 120);
            endcase
            push_cmd(CMD_TICK, 1'($urandom_range(0, 1)), 16'($urandom), stim_ms);
          end
        end
        4: push_cmd(CMD_RAW_SET, ax, pick_value(-20, 260), $urandom);
        5: push_cmd(CMD_LIM_SET, ax, pick_value(-20, 260), $urandom);
        6: push_cmd(CMD_STEP, ax, pick_value(-30, 30), $urandom);
        7: push_cmd(CMD_HOME, ax, 16'($urandom), $urandom);
        default: push_cmd(3'($urandom_range(0, 7)), ax, 16'($urandom), $urandom);
      endcase
    end
  endtask

  // Command driver: a word stays offered until taken, then the next one
  // follows after a random gap.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (cmd_if.valid && taken_cnt == sent_cnt) begin
        // Still waiting for the handshake.
      end else begin
        if (cmd_if.valid) begin
          sent_cnt = taken_cnt;
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_gap = draw_idle(send_burst);
        end
        if (send_gap > 0) begin
          cmd_if.valid <= 1'b0;
          send_gap = send_gap - 1;
        end else if (cmd_q.size() > 0) begin
          drv_word = cmd_q.pop_front();
          cmd_if.command <= drv_word.command;
          cmd_if.axis    <= drv_word.axis;
          cmd_if.value   <= drv_word.value;
          cmd_if.now_ms  <= drv_word.now_ms;
          cmd_if.valid   <= 1'b1;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Readout side back-pressure.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (seen_cnt != rd_cnt) begin
        seen_cnt = rd_cnt;
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_stall = draw_idle(recv_burst);
      end
      if (recv_stall > 0) begin
        rd_if.ready <= 1'b0;
        recv_stall = recv_stall - 1;
      end else begin
        rd_if.ready <= 1'b1;
      end
    end
  end

  // Handshakes at the rising edge: check the readout word first, then predict
  // the one for a newly taken command word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rd_if.valid && rd_if.ready) begin
        got_rd.pan_pulse  = rd_if.pan_pulse_us;
        got_rd.tilt_pulse = rd_if.tilt_pulse_us;
        got_rd.pan_wr     = rd_if.pan_written;
        got_rd.tilt_wr    = rd_if.tilt_written;
        got_rd.pan_deg    = rd_if.pan_deg;
        got_rd.tilt_deg   = rd_if.tilt_deg;
        got_rd.pan_rate   = rd_if.pan_rate_dps;
        got_rd.tilt_rate  = rd_if.tilt_rate_dps;
        if (readout_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) $display("readout %0d arrived with none expected", rd_cnt);
        end else begin
          exp_rd = readout_q.pop_front();
          if (got_rd !== exp_rd) begin
            errors = errors + 1;
            if (errors <= 10) begin
              $display("readout %0d mismatch: pulse %0d/%0d wr %b/%b deg %0d/%0d rate %0d/%0d",
                       rd_cnt, got_rd.pan_pulse, got_rd.tilt_pulse, got_rd.pan_wr,
                       got_rd.tilt_wr, got_rd.pan_deg, got_rd.tilt_deg, got_rd.pan_rate,
                       got_rd.tilt_rate);
              $display("  expected:      pulse %0d/%0d wr %b/%b deg %0d/%0d rate %0d/%0d",
                       exp_rd.pan_pulse, exp_rd.tilt_pulse, exp_rd.pan_wr, exp_rd.tilt_wr,
                       exp_rd.pan_deg, exp_rd.tilt_deg, exp_rd.pan_rate, exp_rd.tilt_rate);
            end
          end
        end
        rd_cnt <= rd_cnt + 1;
      end
      if (cmd_if.valid && cmd_if.ready) begin
        predict_readout(cmd_if.command, cmd_if.axis, cmd_if.value, cmd_if.now_ms, exp_rd);
        readout_q.push_back(exp_rd);
        taken_cnt <= taken_cnt + 1;
      end
    end
  end

  initial begin
    int ph;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    cmd_if.valid   = 1'b0;
    cmd_if.command = CMD_RAW_SET;
    cmd_if.axis    = 1'b0;
    cmd_if.value   = '0;
    cmd_if.now_ms  = '0;
    rd_if.ready    = 1'b0;
    errors     = 0;
    taken_cnt  = 0;
    sent_cnt   = 0;
    rd_cnt     = 0;
    seen_cnt   = 0;
    send_gap   = 0;
    recv_stall = 0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    cfg_reg[REG_PAN_MIN]   = RST_LIM_MIN;
    cfg_reg[REG_PAN_MAX]   = RST_LIM_MAX;
    cfg_reg[REG_TILT_MIN]  = RST_LIM_MIN;
    cfg_reg[REG_TILT_MAX]  = RST_LIM_MAX;
    cfg_reg[REG_MAX_RATE]  = RST_MAX_RATE;
    cfg_reg[REG_MAX_STEP]  = RST_MAX_STEP;
    cfg_reg[REG_PULSE_MIN] = RST_PULSE_MIN;
    cfg_reg[REG_PULSE_MAX] = RST_PULSE_MAX;
    axis_mdeg[0] = PAN_HOME_DEG_DEF * MILLI;
    axis_mdeg[1] = TILT_HOME_DEG_DEF * MILLI;
    axis_rate[0] = 0;
    axis_rate[1] = 0;
    last_tick    = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Register defaults: field extremes, every command, tick corner cases.
    push_cmd(CMD_TICK, 1'b0, 16'sh0000, 32'd0);          // idle tick, nothing moves
    push_cmd(CMD_RAW_SET, 1'b0, 16'sh7FFF, 32'hFFFF_FFFF);
    push_cmd(CMD_RAW_SET, 1'b1, 16'sh8000, 32'd0);
    push_cmd(CMD_LIM_SET, 1'b0, -16'sd5, $urandom);
    push_cmd(CMD_LIM_SET, 1'b1, 16'sd200, $urandom);
    push_cmd(CMD_STEP, 1'b0, 16'sh7FFF, $urandom);
    push_cmd(CMD_STEP, 1'b1, 16'sh8000, $urandom);
    push_cmd(CMD_SET_RATE, 1'b0, 16'sh7FFF, $urandom);
    push_cmd(CMD_SET_RATE, 1'b1, 16'sh8000, $urandom);
    push_cmd(CMD_TICK, 1'b1, 16'shFFFF, 32'd50);         // both axes run into a limit
    push_cmd(CMD_HOME, 1'b1, 16'sh1234, $urandom);
    push_cmd(CMD_SET_RATE, 1'b0, 16'sd45, $urandom);
    push_cmd(CMD_TICK, 1'b0, 16'sh0000, 32'd50);         // zero elapsed time
    push_cmd(CMD_TICK, 1'b0, 16'sh0000, 32'hFFFF_FFF0);  // long gap, clamped
    push_cmd(CMD_TICK, 1'b0, 16'sh0000, 32'h0000_0005);  // timestamp wraps
    push_cmd(CMD_SPARE_6, 1'b0, 16'sd10, $urandom);
    push_cmd(CMD_SPARE_7, 1'b1, 16'sd10, $urandom);
    wait_idle();

    // Inverted limits, a limit above 180, inverted pulse range, zero tick clamp.
    next_regs[REG_PAN_MIN]   = 200;  next_regs[REG_PAN_MAX]   = 100;
    next_regs[REG_TILT_MIN]  = 170;  next_regs[REG_TILT_MAX]  = 255;
    next_regs[REG_MAX_RATE]  = 1000; next_regs[REG_MAX_STEP]  = 0;
    next_regs[REG_PULSE_MIN] = 3000; next_regs[REG_PULSE_MAX] = 100;
    program_regs();
    push_cmd(CMD_LIM_SET, 1'b0, 16'sd150, $urandom);
    push_cmd(CMD_LIM_SET, 1'b0, 16'sd300, $urandom);
    push_cmd(CMD_RAW_SET, 1'b1, 16'sd180, $urandom);
    push_cmd(CMD_STEP, 1'b1, 16'sd60, $urandom);
    push_cmd(CMD_SET_RATE, 1'b1, 16'sd1000, $urandom);
    push_cmd(CMD_TICK, 1'b0, 16'sh0000, 32'd100);
    push_cmd(CMD_HOME, 1'b0, 16'sh0000, $urandom);
    wait_idle();

    for (ph = 0; ph < 6; ph++) begin
      pick_config(ph);
      program_regs();
      stim_ms = (ph % 2 == 1) ? 32'hFFFF_FC00 + $urandom_range(0, 500) : $urandom;
      queue_random(160);
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    errors = errors + readout_q.size();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
design/ptrs_pkg.sv
design/ptrs_if.sv
design/ptrs_ctrl.sv
design/ptrs_datapath.sv
design/pan_tilt_rate_servo_controller_top.sv
verif/testbench.sv
